FILE: design/teq_pkg.sv
`timescale 1ns / 1ps

package teq_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MAX_OUT  = 32;
  localparam int POP_W    = $clog2(MAX_OUT + 1);

  localparam logic [23:0] SAT_MAX = 24'hFFFFFF;

  // Function codes of an input item
  localparam logic [2:0] FN_ADD   = 3'd0;
  localparam logic [2:0] FN_DEL   = 3'd1;
  localparam logic [2:0] FN_TICK  = 3'd2;
  localparam logic [2:0] FN_CMPL  = 3'd3;
  localparam logic [2:0] FN_QUERY = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_NODUE    = 3'd4;

  // Slot life cycle
  localparam logic [1:0] STG_FREE   = 2'd0;
  localparam logic [1:0] STG_QUEUED = 2'd1;
  localparam logic [1:0] STG_FIRED  = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_NEXT,
    CMD_ADD_SETUP,
    CMD_CMP_SETUP,
    CMD_INSERT,
    CMD_DEL,
    CMD_RELEASE,
    CMD_REMQ,
    CMD_TICK,
    CMD_POP,
    CMD_EMIT
  } cmd_op_t;

  typedef enum logic [1:0] {
    AS_SLOT,
    AS_ORDER,
    AS_HEAD
  } addr_sel_t;

  typedef struct packed {
    cmd_op_t   op;
    addr_sel_t asel;
    logic [2:0] status;
    logic       id_zero;
    logic       rem_neg;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       delay_zero;
    logic       cb_zero;
    logic       slot_end;
    logic       order_end;
    logic       free_hit;
    logic       fired_hit;
    logic       queued_hit;
    logic       ins_stop;
    logic       head_due;
    logic       pop_room;
    logic       out_taken;
  } dp_stat_t;

  // Saturated wait from a wrap-safe difference (due minus now)
  function automatic logic [24:0] wait_ms(input logic [31:0] d);
    logic [24:0] w;
    if (d[31]) begin
      w = '0;
    end else if (d[30:24] != '0) begin
      w = {1'b0, SAT_MAX};
    end else begin
      w = {1'b0, d[23:0]};
    end
    return w;
  endfunction

  // Base plus signed offset, not earlier than now
  function automatic logic [31:0] clamp_due(input logic [31:0] base,
                                            input logic [23:0] off,
                                            input logic [31:0] now);
    logic [31:0] due;
    logic [31:0] d;
    due = base + {{8{off[23]}}, off};
    d   = due - now;
    if (d[31]) begin
      due = now;
    end
    return due;
  endfunction

endpackage

FILE: design/teq_ctrl.sv
`timescale 1ns / 1ps

module teq_ctrl
  import teq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_AFIND,
    S_ISCAN,
    S_QFIND,
    S_CFIND,
    S_TCHK,
    S_EMIT,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] st_r, st_nxt;
  logic       idz_r, idz_nxt;
  logic       rn_r, rn_nxt;
  logic       more_r, more_nxt;
  logic       more;

  assign in_stall = (state_r != S_IDLE);

  // Decide the next step and the datapath command
  always_comb begin
    state_nxt   = state_r;
    st_nxt      = st_r;
    idz_nxt     = idz_r;
    rn_nxt      = rn_r;
    more_nxt    = more_r;
    cmd.op      = CMD_NONE;
    cmd.asel    = AS_SLOT;
    cmd.status  = st_r;
    cmd.id_zero = idz_r;
    cmd.rem_neg = rn_r;
    cmd.last    = 1'b1;
    more        = (stat.func == FN_TICK) && (st_r == ST_OK) &&
                  stat.head_due && stat.pop_room;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_LOAD;
          st_nxt    = ST_OK;
          idz_nxt   = 1'b0;
          rn_nxt    = 1'b0;
          more_nxt  = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.func) inside
          FN_ADD: begin
            if (stat.delay_zero) begin
              st_nxt    = ST_ZERO;
              idz_nxt   = 1'b1;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_AFIND;
            end
          end
          FN_DEL, FN_QUERY: state_nxt = S_QFIND;
          FN_TICK: begin
            cmd.op    = CMD_TICK;
            state_nxt = S_TCHK;
          end
          FN_CMPL: state_nxt = S_CFIND;
          default: state_nxt = S_EMIT;
        endcase
      end
      S_AFIND: begin
        cmd.asel = AS_SLOT;
        if (stat.slot_end) begin
          st_nxt    = ST_FULL;
          idz_nxt   = 1'b1;
          state_nxt = S_EMIT;
        end else if (stat.free_hit) begin
          cmd.op    = CMD_ADD_SETUP;
          state_nxt = S_ISCAN;
        end else begin
          cmd.op = CMD_NEXT;
        end
      end
      S_ISCAN: begin
        cmd.asel = AS_ORDER;
        if (stat.order_end || stat.ins_stop) begin
          cmd.op    = CMD_INSERT;
          state_nxt = S_EMIT;
        end else begin
          cmd.op = CMD_NEXT;
        end
      end
      S_QFIND: begin
        cmd.asel = AS_ORDER;
        if (stat.order_end) begin
          st_nxt    = ST_NOTFOUND;
          rn_nxt    = (stat.func == FN_QUERY);
          state_nxt = S_EMIT;
        end else if (stat.queued_hit) begin
          cmd.op    = (stat.func == FN_DEL) ? CMD_DEL : CMD_REMQ;
          state_nxt = S_EMIT;
        end else begin
          cmd.op = CMD_NEXT;
        end
      end
      S_CFIND: begin
        cmd.asel = AS_SLOT;
        if (stat.slot_end) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_EMIT;
        end else if (stat.fired_hit) begin
          cmd.op    = stat.cb_zero ? CMD_RELEASE : CMD_CMP_SETUP;
          state_nxt = stat.cb_zero ? S_EMIT : S_ISCAN;
        end else begin
          cmd.op = CMD_NEXT;
        end
      end
      S_TCHK: begin
        cmd.asel = AS_HEAD;
        if (stat.head_due) begin
          cmd.op = CMD_POP;
        end else begin
          st_nxt  = ST_NODUE;
          idz_nxt = 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.asel  = AS_HEAD;
        cmd.op    = CMD_EMIT;
        cmd.last  = !more;
        more_nxt  = more;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_taken) begin
          if (more_r) begin
            cmd.op    = CMD_POP;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and pending result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
      idz_r   <= 1'b0;
      rn_r    <= 1'b0;
      more_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      idz_r   <= idz_nxt;
      rn_r    <= rn_nxt;
      more_r  <= more_nxt;
    end
  end

endmodule

FILE: design/teq_dp.sv
`timescale 1ns / 1ps

module teq_dp
  import teq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [2:0]         in_func,
  input  logic signed [23:0] in_delay_ms,
  input  logic               in_use_return_interval,
  input  logic [15:0]        in_event_id,
  input  logic signed [23:0] in_callback_result,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [15:0]        out_result_id,
  output logic signed [24:0] out_remaining_ms,
  output logic signed [24:0] out_first_wait_ms,
  output logic [5:0]         out_queued_count,
  output logic               out_last
);

  // Event table
  logic [31:0]      due_r   [CAPACITY];
  logic [15:0]      ident_r [CAPACITY];
  logic [23:0]      intv_r  [CAPACITY];
  logic             user_r  [CAPACITY];
  logic [1:0]       stage_r [CAPACITY];
  logic [IDX_W-1:0] order_r [CAPACITY];

  logic [31:0]      now_r;
  logic [15:0]      next_id_r;
  logic [CNT_W-1:0] len_r;

  // Per-item working registers
  logic [2:0]       func_r;
  logic [23:0]      delay_r;
  logic             use_ret_r;
  logic [15:0]      id_r;
  logic [23:0]      cb_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] slot_r;
  logic [31:0]      newdue_r;
  logic [15:0]      res_id_r;
  logic [24:0]      rem_r;
  logic [POP_W-1:0] npop_r;

  // Result register
  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [15:0]      out_id_r;
  logic [24:0]      out_rem_r;
  logic [24:0]      out_fw_r;
  logic [5:0]       out_cnt_r;
  logic             out_last_r;

  logic [IDX_W-1:0] cidx;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd_due;
  logic [31:0]      head_diff;
  logic [31:0]      ins_diff;
  logic             taken;

  assign cidx = cnt_r[IDX_W-1:0];

  // Select the one table address read this cycle
  always_comb begin
    case (cmd.asel)
      AS_SLOT:  rd_addr = cidx;
      AS_ORDER: rd_addr = order_r[cidx];
      default:  rd_addr = order_r[0];
    endcase
  end

  assign rd_due    = due_r[rd_addr];
  assign head_diff = rd_due - now_r;
  assign ins_diff  = newdue_r - rd_due;
  assign taken     = out_valid_r && !out_stall;

  // Report conditions to the controller
  always_comb begin
    stat.func       = func_r;
    stat.delay_zero = (delay_r == '0);
    stat.cb_zero    = (cb_r == '0);
    stat.slot_end   = (cnt_r == CNT_W'(CAPACITY));
    stat.order_end  = (cnt_r == len_r);
    stat.free_hit   = (stage_r[rd_addr] == STG_FREE);
    stat.fired_hit  = (stage_r[rd_addr] == STG_FIRED) && (ident_r[rd_addr] == id_r);
    stat.queued_hit = (ident_r[rd_addr] == id_r);
    stat.ins_stop   = ins_diff[31];
    stat.head_due   = (len_r != '0) && (head_diff[31] || (head_diff == '0));
    stat.pop_room   = (npop_r < POP_W'(MAX_OUT));
    stat.out_taken  = taken;
  end

  // Carry out the datapath command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) begin
        stage_r[i] <= STG_FREE;
      end
      now_r       <= '0;
      next_id_r   <= 16'd1;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (taken) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        CMD_NONE: ;
        CMD_LOAD: begin
          func_r    <= in_func;
          delay_r   <= in_delay_ms;
          use_ret_r <= in_use_return_interval;
          id_r      <= in_event_id;
          cb_r      <= in_callback_result;
          cnt_r     <= '0;
          res_id_r  <= in_event_id;
          rem_r     <= '0;
          npop_r    <= '0;
        end
        CMD_NEXT: cnt_r <= cnt_r + 1'b1;
        CMD_ADD_SETUP: begin
          slot_r           <= rd_addr;
          ident_r[rd_addr] <= next_id_r;
          intv_r[rd_addr]  <= delay_r;
          user_r[rd_addr]  <= use_ret_r;
          newdue_r         <= clamp_due(now_r, delay_r, now_r);
          res_id_r         <= next_id_r;
          next_id_r        <= next_id_r + 16'd1;
          cnt_r            <= '0;
        end
        CMD_CMP_SETUP: begin
          slot_r   <= rd_addr;
          newdue_r <= clamp_due(rd_due, user_r[rd_addr] ? cb_r : intv_r[rd_addr], now_r);
          cnt_r    <= '0;
        end
        CMD_INSERT: begin
          for (int i = CAPACITY - 1; i > 0; i--) begin
            if (CNT_W'(i) > cnt_r) begin
              order_r[i] <= order_r[i-1];
            end
          end
          order_r[cidx]   <= slot_r;
          due_r[slot_r]   <= newdue_r;
          stage_r[slot_r] <= STG_QUEUED;
          len_r           <= len_r + 1'b1;
        end
        CMD_DEL: begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (CNT_W'(i) >= cnt_r) begin
              order_r[i] <= order_r[i+1];
            end
          end
          stage_r[rd_addr] <= STG_FREE;
          len_r            <= len_r - 1'b1;
        end
        CMD_RELEASE: stage_r[rd_addr] <= STG_FREE;
        CMD_REMQ:    rem_r <= wait_ms(head_diff);
        CMD_TICK:    now_r <= now_r + 32'd1;
        CMD_POP: begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            order_r[i] <= order_r[i+1];
          end
          stage_r[order_r[0]] <= STG_FIRED;
          res_id_r            <= ident_r[order_r[0]];
          len_r               <= len_r - 1'b1;
          npop_r              <= npop_r + 1'b1;
        end
        CMD_EMIT: begin
          out_valid_r  <= 1'b1;
          out_status_r <= cmd.status;
          out_id_r     <= cmd.id_zero ? 16'd0 : res_id_r;
          out_rem_r    <= cmd.rem_neg ? '1 : rem_r;
          out_fw_r     <= (len_r == '0) ? '1 : wait_ms(head_diff);
          out_cnt_r    <= 6'(len_r);
          out_last_r   <= cmd.last;
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_id     = out_id_r;
  assign out_remaining_ms  = out_rem_r;
  assign out_first_wait_ms = out_fw_r;
  assign out_queued_count  = out_cnt_r;
  assign out_last          = out_last_r;

endmodule

FILE: design/timed_event_queue_unit.sv
`timescale 1ns / 1ps

// Timed event queue: up to 32 events kept in due-time order against a
// millisecond clock. One item is worked at a time; in_stall stays high from
// acceptance until the last result of that item has been taken. A sequencer
// walks the table one entry per cycle, so an add or a complete runs a slot
// search, then a sorted-position search when it queues an event, a delete or
// query one search of the sorted order, and a tick pops each due event as
// its own result; any result may also wait under out_stall.
// Every result carries the wait until the earliest event and the queue length.

module timed_event_queue_unit
  import teq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [23:0] in_delay_ms,
  input  logic               in_use_return_interval,
  input  logic [15:0]        in_event_id,
  input  logic signed [23:0] in_callback_result,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [15:0]        out_result_id,
  output logic signed [24:0] out_remaining_ms,
  output logic signed [24:0] out_first_wait_ms,
  output logic [5:0]         out_queued_count,
  output logic               out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  teq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  teq_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .stat                   (stat),
    .in_func                (in_func),
    .in_delay_ms            (in_delay_ms),
    .in_use_return_interval (in_use_return_interval),
    .in_event_id            (in_event_id),
    .in_callback_result     (in_callback_result),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_result_id          (out_result_id),
    .out_remaining_ms       (out_remaining_ms),
    .out_first_wait_ms      (out_first_wait_ms),
    .out_queued_count       (out_queued_count),
    .out_last               (out_last)
  );

  // A pending result keeps the input side closed
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result pending while input open");

  // An accepted item closes the input side next cycle
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("input not closed");

  // Nothing due is always a single, final result
  a_nodue_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NODUE)) |-> out_last)
    else $error("nothing-due result not last");

  // Queue length never exceeds the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_queued_count <= 6'(CAPACITY)))
    else $error("queue count out of range");

endmodule
